@@ rtl/brat_pkg.sv @@
// Shared constants and types for the best rational approximation core.
`timescale 1ns / 1ps
`default_nettype none

package brat_pkg;

    localparam int CFG_W            = 16;
    localparam int DEN_W            = 16;
    localparam int ITER_OUT_W       = 7;
    localparam int STATUS_W         = 2;
    localparam int STEP_W           = 6;
    localparam int NEAR_W           = DEN_W + 4;
    localparam int MUL_STEPS        = DEN_W;
    localparam int JUMP_STEPS       = DEN_W + 1;
    localparam int CLAMP_STEPS      = DEN_W;
    localparam int TARGET_FRAC_DEF  = 32;
    localparam int ITER_LIMIT_DEF   = 100;

    localparam logic [CFG_W-1:0]    MAXDEN_RESET = 16'd4095;
    localparam logic [DEN_W-1:0]    JUMP_MAX     = 16'hFFFF;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ABOVE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BELOW = 2'd2;

    typedef struct packed {
        logic              go;
        logic              div;
        logic [STEP_W-1:0] steps;
    } alu_req_t;

endpackage

`default_nettype wire

@@ rtl/brat_alu.sv @@
// Shared shift-add multiplier and shift-subtract divider, one step per cycle.
`timescale 1ns / 1ps
`default_nettype none

module brat_alu #(
    parameter int UW = 52,
    parameter int QW = 33
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  brat_pkg::alu_req_t   req,
    input  wire  [UW-1:0]        x,
    input  wire  [UW-1:0]        y,
    output logic                 done,
    output logic [UW-1:0]        acc,
    output logic [QW-1:0]        quo
);

    logic [UW-1:0]               acc_reg, acc_next;
    logic [UW-1:0]               opr_reg, opr_next;
    logic [QW-1:0]               mq_reg, mq_next;
    logic [brat_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic                        run_reg, run_next;
    logic                        div_reg, div_next;
    logic                        done_reg, done_next;
    logic [UW-1:0]               addend;
    logic [UW:0]                 sum;

    assign addend = div_reg ? ~opr_reg : opr_reg;
    assign sum    = {1'b0, acc_reg} + {1'b0, addend} + (UW+1)'(div_reg);

    always_comb
    begin
        acc_next  = acc_reg;
        opr_next  = opr_reg;
        mq_next   = mq_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        if (req.go)
        begin
            acc_next = req.div ? x : '0;
            opr_next = req.div ? y : x;
            mq_next  = req.div ? '0 : QW'(y[brat_pkg::MUL_STEPS-1:0]);
            cnt_next = req.steps;
            run_next = 1'b1;
            div_next = req.div;
        end
        else if (run_reg)
        begin
            if (div_reg)
            begin
                // carry out means remainder >= shifted divisor
                if (sum[UW])
                begin
                    acc_next = sum[UW-1:0];
                end
                mq_next  = {mq_reg[QW-2:0], sum[UW]};
                opr_next = opr_reg >> 1;
            end
            else
            begin
                if (mq_reg[0])
                begin
                    acc_next = sum[UW-1:0];
                end
                mq_next  = mq_reg >> 1;
                opr_next = opr_reg << 1;
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == brat_pkg::STEP_W'(1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            div_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            div_reg  <= div_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        opr_reg <= opr_next;
        mq_reg  <= mq_next;
    end

    assign done = done_reg;
    assign acc  = acc_reg;
    assign quo  = mq_reg;

endmodule

`default_nettype wire

@@ rtl/best_rational_approximation_core.sv @@
// Top level: Farey interval search for the best fraction under a denominator limit.
// A target above one or below zero goes straight to the output stage. Otherwise the
// core computes the closeness threshold, then runs narrowing steps (check, jump divide,
// clamp divide, three shift-add multiplies in the shared unit), ending either in a check
// or in a final endpoint pick. One item at a time.
// Reset clears control state and sets max_denominator to 4095.
`timescale 1ns / 1ps
`default_nettype none

module best_rational_approximation_core #(
    parameter int TARGET_FRAC_BITS = brat_pkg::TARGET_FRAC_DEF,
    parameter int ITER_LIMIT       = brat_pkg::ITER_LIMIT_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 in_valid,
    output logic                                in_stall,
    input  wire  [TARGET_FRAC_BITS+1:0]         target,
    output logic                                out_valid,
    input  wire                                 out_stall,
    output logic [brat_pkg::DEN_W-1:0]          numerator,
    output logic [brat_pkg::DEN_W-1:0]          denominator,
    output logic [brat_pkg::ITER_OUT_W-1:0]     iteration_count,
    output logic [brat_pkg::STATUS_W-1:0]       status,
    input  wire                                 cfg_valid,
    output logic                                cfg_ready,
    input  wire  [brat_pkg::CFG_W-1:0]          max_denominator
);

    localparam int F  = TARGET_FRAC_BITS;
    localparam int TW = F + 2;
    localparam int GW = F + 1;
    localparam int UW = F + brat_pkg::NEAR_W;
    localparam int QW = F + 1;
    localparam int IW = $clog2(ITER_LIMIT + 2);
    localparam int DW = brat_pkg::DEN_W;
    localparam int OW = brat_pkg::ITER_OUT_W;
    localparam int SW = brat_pkg::STATUS_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_THR  = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_JDIV = 4'd3;
    localparam logic [3:0] S_CDIV = 4'd4;
    localparam logic [3:0] S_MGAP = 4'd5;
    localparam logic [3:0] S_MNUM = 4'd6;
    localparam logic [3:0] S_MDEN = 4'd7;
    localparam logic [3:0] S_FM1  = 4'd8;
    localparam logic [3:0] S_FM2  = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    localparam logic [GW-1:0] ONE = GW'(1) << F;

    logic [3:0]    state_reg, state_next;
    logic [DW-1:0] a_reg, a_next, b_reg, b_next, c_reg, c_next, d_reg, d_next;
    logic [GW-1:0] lgap_reg, lgap_next, rgap_reg, rgap_next;
    logic [F-1:0]  thr_reg, thr_next;
    logic [IW-1:0] ii_reg, ii_next;
    logic          dir_reg, dir_next;
    logic [DW-1:0] jq_reg, jq_next, n_reg, n_next, m_reg, m_next;
    logic [UW-1:0] prod_reg, prod_next;
    logic [brat_pkg::CFG_W-1:0] maxden_reg;
    logic [DW-1:0] res_num_reg, res_num_next, res_den_reg, res_den_next;
    logic [OW-1:0] res_iter_reg, res_iter_next;
    logic [SW-1:0] res_stat_reg, res_stat_next;
    logic          out_valid_reg, out_valid_next;
    logic [DW-1:0] out_num_reg, out_num_next, out_den_reg, out_den_next;
    logic [OW-1:0] out_iter_reg, out_iter_next;
    logic [SW-1:0] out_stat_reg, out_stat_next;

    brat_pkg::alu_req_t req;
    logic [UW-1:0] alu_x, alu_y, alu_acc;
    logic [QW-1:0] alu_quo;
    logic          alu_done;

    logic [DW-1:0]                m_eff;
    logic [brat_pkg::NEAR_W-1:0]  near_k;
    logic [DW:0]                  qsum;
    logic [IW-1:0]                ii_inc;
    logic [DW-1:0]                jq_sat, n_min;

    brat_alu #(
        .UW (UW),
        .QW (QW)
    ) u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .x     (alu_x),
        .y     (alu_y),
        .done  (alu_done),
        .acc   (alu_acc),
        .quo   (alu_quo)
    );

    assign m_eff  = (maxden_reg == '0) ? DW'(1) : maxden_reg;
    assign near_k = {2'b00, m_eff, 2'b00} + {3'b000, m_eff, 1'b0} + {m_eff, 4'b0000}
                    - {2'b00, m_eff, 2'b00} - {m_eff, 4'b0000} + {1'b0, m_eff, 3'b000};
    assign qsum   = {1'b0, b_reg} + {1'b0, d_reg};
    assign ii_inc = ii_reg + 1'b1;
    assign jq_sat = alu_quo[DW] ? brat_pkg::JUMP_MAX : alu_quo[DW-1:0];
    assign n_min  = (jq_reg < alu_quo[DW-1:0]) ? jq_reg : alu_quo[DW-1:0];

    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        c_next         = c_reg;
        d_next         = d_reg;
        lgap_next      = lgap_reg;
        rgap_next      = rgap_reg;
        thr_next       = thr_reg;
        ii_next        = ii_reg;
        dir_next       = dir_reg;
        jq_next        = jq_reg;
        n_next         = n_reg;
        m_next         = m_reg;
        prod_next      = prod_reg;
        res_num_next   = res_num_reg;
        res_den_next   = res_den_reg;
        res_iter_next  = res_iter_reg;
        res_stat_next  = res_stat_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_num_next   = out_num_reg;
        out_den_next   = out_den_reg;
        out_iter_next  = out_iter_reg;
        out_stat_next  = out_stat_reg;
        req            = '{go: 1'b0, div: 1'b0, steps: '0};
        alu_x          = '0;
        alu_y          = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (target[TW-1])
                    begin
                        res_num_next  = '0;
                        res_den_next  = DW'(1);
                        res_iter_next = '0;
                        res_stat_next = brat_pkg::STATUS_BELOW;
                        state_next    = S_DONE;
                    end
                    else if (target[F] && (|target[F-1:0]))
                    begin
                        res_num_next  = DW'(1);
                        res_den_next  = DW'(1);
                        res_iter_next = '0;
                        res_stat_next = brat_pkg::STATUS_ABOVE;
                        state_next    = S_DONE;
                    end
                    else
                    begin
                        a_next    = '0;
                        b_next    = DW'(1);
                        c_next    = DW'(1);
                        d_next    = DW'(1);
                        lgap_next = target[GW-1:0];
                        rgap_next = ONE - target[GW-1:0];
                        ii_next   = '0;
                        m_next    = m_eff;
                        // closeness threshold: floor((2^F - 1) / (10 * max))
                        req       = '{go: 1'b1, div: 1'b1, steps: brat_pkg::STEP_W'(F)};
                        alu_x     = UW'({F{1'b1}});
                        alu_y     = UW'(near_k) << (F - 1);
                        state_next = S_THR;
                    end
                end
            end
            S_THR:
            begin
                if (alu_done)
                begin
                    thr_next   = alu_quo[F-1:0];
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                if ((qsum > {1'b0, m_reg}) || (ii_reg > IW'(ITER_LIMIT)))
                begin
                    req        = '{go: 1'b1, div: 1'b0,
                                   steps: brat_pkg::STEP_W'(brat_pkg::MUL_STEPS)};
                    alu_x      = UW'(lgap_reg);
                    alu_y      = UW'(d_reg);
                    state_next = S_FM1;
                end
                else
                begin
                    ii_next       = ii_inc;
                    res_iter_next = OW'(ii_inc);
                    res_stat_next = brat_pkg::STATUS_OK;
                    if (lgap_reg < rgap_reg)
                    begin
                        if (lgap_reg <= {1'b0, thr_reg})
                        begin
                            res_num_next = a_reg;
                            res_den_next = b_reg;
                            state_next   = S_DONE;
                        end
                        else
                        begin
                            dir_next   = 1'b0;
                            req        = '{go: 1'b1, div: 1'b1,
                                           steps: brat_pkg::STEP_W'(brat_pkg::JUMP_STEPS)};
                            alu_x      = UW'(rgap_reg);
                            alu_y      = UW'(lgap_reg) << DW;
                            state_next = S_JDIV;
                        end
                    end
                    else
                    begin
                        if (rgap_reg <= {1'b0, thr_reg})
                        begin
                            res_num_next = c_reg;
                            res_den_next = d_reg;
                            state_next   = S_DONE;
                        end
                        else
                        begin
                            dir_next   = 1'b1;
                            req        = '{go: 1'b1, div: 1'b1,
                                           steps: brat_pkg::STEP_W'(brat_pkg::JUMP_STEPS)};
                            alu_x      = UW'(lgap_reg);
                            alu_y      = UW'(rgap_reg) << DW;
                            state_next = S_JDIV;
                        end
                    end
                end
            end
            S_JDIV:
            begin
                if (alu_done)
                begin
                    jq_next = (jq_sat == '0) ? DW'(1) : jq_sat;
                    // largest jump that keeps the moved denominator in range
                    req     = '{go: 1'b1, div: 1'b1,
                                steps: brat_pkg::STEP_W'(brat_pkg::CLAMP_STEPS)};
                    alu_x   = UW'(m_reg - (dir_reg ? b_reg : d_reg));
                    alu_y   = UW'(dir_reg ? d_reg : b_reg) << (DW - 1);
                    state_next = S_CDIV;
                end
            end
            S_CDIV:
            begin
                if (alu_done)
                begin
                    n_next     = n_min;
                    req        = '{go: 1'b1, div: 1'b0,
                                   steps: brat_pkg::STEP_W'(brat_pkg::MUL_STEPS)};
                    alu_x      = UW'(dir_reg ? rgap_reg : lgap_reg);
                    alu_y      = UW'(n_min);
                    state_next = S_MGAP;
                end
            end
            S_MGAP:
            begin
                if (alu_done)
                begin
                    if (dir_reg)
                    begin
                        lgap_next = lgap_reg - alu_acc[GW-1:0];
                    end
                    else
                    begin
                        rgap_next = rgap_reg - alu_acc[GW-1:0];
                    end
                    req        = '{go: 1'b1, div: 1'b0,
                                   steps: brat_pkg::STEP_W'(brat_pkg::MUL_STEPS)};
                    alu_x      = UW'(dir_reg ? c_reg : a_reg);
                    alu_y      = UW'(n_reg);
                    state_next = S_MNUM;
                end
            end
            S_MNUM:
            begin
                if (alu_done)
                begin
                    if (dir_reg)
                    begin
                        a_next = a_reg + alu_acc[DW-1:0];
                    end
                    else
                    begin
                        c_next = c_reg + alu_acc[DW-1:0];
                    end
                    req        = '{go: 1'b1, div: 1'b0,
                                   steps: brat_pkg::STEP_W'(brat_pkg::MUL_STEPS)};
                    alu_x      = UW'(dir_reg ? d_reg : b_reg);
                    alu_y      = UW'(n_reg);
                    state_next = S_MDEN;
                end
            end
            S_MDEN:
            begin
                if (alu_done)
                begin
                    if (dir_reg)
                    begin
                        b_next = b_reg + alu_acc[DW-1:0];
                    end
                    else
                    begin
                        d_next = d_reg + alu_acc[DW-1:0];
                    end
                    state_next = S_CHK;
                end
            end
            S_FM1:
            begin
                if (alu_done)
                begin
                    prod_next  = alu_acc;
                    req        = '{go: 1'b1, div: 1'b0,
                                   steps: brat_pkg::STEP_W'(brat_pkg::MUL_STEPS)};
                    alu_x      = UW'(rgap_reg);
                    alu_y      = UW'(b_reg);
                    state_next = S_FM2;
                end
            end
            S_FM2:
            begin
                if (alu_done)
                begin
                    // pick the nearer endpoint, c/d on a tie
                    if (prod_reg < alu_acc)
                    begin
                        res_num_next = a_reg;
                        res_den_next = b_reg;
                    end
                    else
                    begin
                        res_num_next = c_reg;
                        res_den_next = d_reg;
                    end
                    res_iter_next = OW'(ii_reg);
                    res_stat_next = brat_pkg::STATUS_OK;
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_num_next   = res_num_reg;
                    out_den_next   = res_den_reg;
                    out_iter_next  = res_iter_reg;
                    out_stat_next  = res_stat_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            maxden_reg    <= brat_pkg::MAXDEN_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                maxden_reg <= max_denominator;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        c_reg        <= c_next;
        d_reg        <= d_next;
        lgap_reg     <= lgap_next;
        rgap_reg     <= rgap_next;
        thr_reg      <= thr_next;
        ii_reg       <= ii_next;
        dir_reg      <= dir_next;
        jq_reg       <= jq_next;
        n_reg        <= n_next;
        m_reg        <= m_next;
        prod_reg     <= prod_next;
        res_num_reg  <= res_num_next;
        res_den_reg  <= res_den_next;
        res_iter_reg <= res_iter_next;
        res_stat_reg <= res_stat_next;
        out_num_reg  <= out_num_next;
        out_den_reg  <= out_den_next;
        out_iter_reg <= out_iter_next;
        out_stat_reg <= out_stat_next;
    end

    assign in_stall        = (state_reg != S_IDLE);
    assign cfg_ready       = 1'b1;
    assign out_valid       = out_valid_reg;
    assign numerator       = out_num_reg;
    assign denominator     = out_den_reg;
    assign iteration_count = out_iter_reg;
    assign status          = out_stat_reg;

endmodule

`default_nettype wire

@@ tb/best_rational_approximation_checker.sv @@
// Checker for the rational approximation core: predicts each result and compares.
`timescale 1ns / 1ps

module best_rational_approximation_checker
    import brat_pkg::*;
#(
    parameter int TARGET_FRAC_BITS = 32,
    parameter int ITER_LIMIT       = 100
) (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          in_valid,
    input  wire                          in_stall,
    input  wire [TARGET_FRAC_BITS+1:0]   target,
    input  wire                          out_valid,
    input  wire                          out_stall,
    input  wire [DEN_W-1:0]              numerator,
    input  wire [DEN_W-1:0]              denominator,
    input  wire [ITER_OUT_W-1:0]         iteration_count,
    input  wire [STATUS_W-1:0]           status,
    input  wire                          cfg_valid,
    input  wire                          cfg_ready,
    input  wire [CFG_W-1:0]              max_denominator,
    output int                           fraction_errors,
    output int                           fractions_pending,
    output int                           fractions_seen
);

    localparam int TGT_W = TARGET_FRAC_BITS + 2;

    typedef struct packed {
        logic [DEN_W-1:0]      num;
        logic [DEN_W-1:0]      den;
        logic [ITER_OUT_W-1:0] iters;
        logic [STATUS_W-1:0]   stat;
    } fraction_t;

    fraction_t        expected_fractions[$];
    logic [CFG_W-1:0] den_limit;

    function automatic fraction_t best_fraction(logic [TGT_W-1:0] raw, logic [CFG_W-1:0] lim);
        fraction_t    r;
        logic [127:0] one, x, lg, rg, num, dv, t;
        logic [63:0]  m, a, b, c, d, p, q, n;
        int           ii, k;
        bit           done;
        one  = 128'd1 << TARGET_FRAC_BITS;
        x    = 128'(raw);
        m    = (lim == 0) ? 64'd1 : 64'(lim);
        a    = 0; b = 1; c = 1; d = 1; ii = 0; done = 0;
        r.stat = STATUS_OK;
        if (raw[TGT_W-1]) begin
            r.num = 0; r.den = 1; r.iters = 0; r.stat = STATUS_BELOW;
            return r;
        end
        if (x > one) begin
            r.num = 1; r.den = 1; r.iters = 0; r.stat = STATUS_ABOVE;
            return r;
        end
        while (!done) begin
            p  = a + c;
            q  = b + d;
            lg = x * b - (128'(a) << TARGET_FRAC_BITS);
            rg = (128'(c) << TARGET_FRAC_BITS) - x * d;
            if (q > m || ii > ITER_LIMIT) begin
                // nearer endpoint, ties go right
                if (lg * d < rg * b) begin p = a; q = b; end
                else begin p = c; q = d; end
                done = 1;
            end else begin
                ii++;
                if (x * q < (128'(p) << TARGET_FRAC_BITS)) begin
                    if (lg * (128'(m) * 10) < one) begin p = a; q = b; done = 1; end
                    else begin
                        num = rg; dv = lg; n = 0;
                        for (k = 16; k >= 0; k--) begin
                            t = dv << k;
                            if (num >= t) begin num -= t; n |= 64'd1 << k; end
                        end
                        if (n > 65535) n = 65535;
                        if (n < 1) n = 1;
                        if (d + n * b > m) n = (m - d) / b;
                        c += n * a;
                        d += n * b;
                    end
                end else begin
                    if (rg * (128'(m) * 10) < one) begin p = c; q = d; done = 1; end
                    else begin
                        num = lg; dv = rg; n = 0;
                        for (k = 16; k >= 0; k--) begin
                            t = dv << k;
                            if (num >= t) begin num -= t; n |= 64'd1 << k; end
                        end
                        if (n > 65535) n = 65535;
                        if (n < 1) n = 1;
                        if (b + n * d > m) n = (m - b) / d;
                        a += n * c;
                        b += n * d;
                    end
                end
            end
        end
        r.num   = p[DEN_W-1:0];
        r.den   = q[DEN_W-1:0];
        r.iters = ii[ITER_OUT_W-1:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fraction_t want, got;
        if (!rst_n)
        begin
            den_limit         = MAXDEN_RESET;
            fraction_errors   = 0;
            fractions_seen    = 0;
            fractions_pending = 0;
            expected_fractions.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                den_limit = max_denominator;
            if (in_valid && !in_stall)
                expected_fractions.push_back(best_fraction(target, den_limit));
            if (out_valid && !out_stall)
            begin
                got = '{numerator, denominator, iteration_count, status};
                fractions_seen++;
                if (expected_fractions.size() == 0)
                begin
                    fraction_errors++;
                    if (fraction_errors <= 10)
                        $display("unexpected result beat %0d/%0d it=%0d st=%0d",
                                 got.num, got.den, got.iters, got.stat);
                end
                else
                begin
                    want = expected_fractions.pop_front();
                    if (got != want)
                    begin
                        fraction_errors++;
                        if (fraction_errors <= 10)
                            $display({"result %0d: want %0d/%0d it=%0d st=%0d, ",
                                      "got %0d/%0d it=%0d st=%0d"},
                                     fractions_seen, want.num, want.den, want.iters,
                                     want.stat, got.num, got.den, got.iters, got.stat);
                    end
                end
            end
            fractions_pending = expected_fractions.size();
        end
    end

endmodule

@@ tb/best_rational_approximation_core_tb.sv @@
// Testbench top for the rational approximation core: stimulus, idling and verdict.
`timescale 1ns / 1ps

module best_rational_approximation_core_tb;
    import brat_pkg::*;

    localparam int  TFB       = 32;
    localparam int  TGT_W     = TFB + 2;
    localparam longint CYCLE_LIMIT = 60_000_000;
    localparam logic [TGT_W-1:0] ONE_FIX = 34'd1 << TFB;

    logic                  clk = 0;
    logic                  rst_n = 0;
    logic                  in_valid = 0;
    logic                  in_stall;
    logic [TGT_W-1:0]      target = '0;
    logic                  out_valid;
    logic                  out_stall = 0;
    logic [DEN_W-1:0]      numerator, denominator;
    logic [ITER_OUT_W-1:0] iteration_count;
    logic [STATUS_W-1:0]   status;
    logic                  cfg_valid = 0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      max_denominator = '0;

    int     fraction_errors, fractions_pending, fractions_seen;
    int     burst_left = 0;
    longint cycles = 0;

    always #10 clk = ~clk;

    best_rational_approximation_core #(.TARGET_FRAC_BITS(TFB), .ITER_LIMIT(100)) i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .target(target),
        .out_valid(out_valid), .out_stall(out_stall),
        .numerator(numerator), .denominator(denominator),
        .iteration_count(iteration_count), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .max_denominator(max_denominator)
    );

    best_rational_approximation_checker #(.TARGET_FRAC_BITS(TFB), .ITER_LIMIT(100)) i_checker (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .target(target),
        .out_valid(out_valid), .out_stall(out_stall),
        .numerator(numerator), .denominator(denominator),
        .iteration_count(iteration_count), .status(status),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .max_denominator(max_denominator),
        .fraction_errors(fraction_errors), .fractions_pending(fractions_pending),
        .fractions_seen(fractions_seen)
    );

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("best_rational_approximation_core: mismatch");
            $finish;
        end
    end

    // Receiver: one long hold-off to back the core up, otherwise shifting stall patterns.
    initial
    begin
        int  mode, hold;
        bit  held;
        mode = 0; held = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && fractions_seen >= 40)
            begin
                held = 1;
                out_stall = 1;
                for (hold = 0; hold < 4000; hold++)
                    @(negedge clk);
            end
            if ($urandom_range(0, 63) == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0:       out_stall = 0;
                1:       out_stall = ($urandom_range(0, 3) == 0);
                2:       out_stall = ($urandom_range(0, 3) != 0);
                default: out_stall = $urandom_range(0, 1);
            endcase
        end
    end

    task automatic send_target(logic [TGT_W-1:0] value);
        int gap;
        if (burst_left == 0)
        begin
            in_valid = 0;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_valid = 1;
        target   = value;
        do
            @(posedge clk);
        while (in_stall);
        @(negedge clk);
        in_valid = 0;
        target   = {$urandom, $urandom};
    endtask

    task automatic write_den_limit(logic [CFG_W-1:0] value);
        wait (fractions_pending == 0);
        repeat (40) @(negedge clk);
        cfg_valid       = 1;
        max_denominator = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 0;
    endtask

    function automatic logic [TGT_W-1:0] random_target();
        logic [63:0] wide;
        logic [31:0] pn, qd;
        wide = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return wide[TGT_W-1:0];
            1: return {1'b1, wide[TGT_W-2:0]};
            2: return ONE_FIX + 1 + (wide[TGT_W-1:0] % (ONE_FIX - 1));
            3: return ONE_FIX - $urandom_range(0, 3);
            4:
            begin
                // exact fractions with small denominators
                qd = $urandom_range(1, 300);
                pn = $urandom_range(0, qd);
                return TGT_W'((64'(pn) << TFB) / qd);
            end
            default: return {2'b00, wide[31:0]};
        endcase
    endfunction

    initial
    begin
        logic [CFG_W-1:0] limits[8];
        int               ph, i;
        limits = '{16'd0, 16'd1, 16'hFFFF, 16'd2, 16'd7, 16'd100, 16'd255, 16'd4095};
        repeat (6) @(negedge clk);
        rst_n = 1;
        repeat (2) @(negedge clk);

        // directed: field extremes, both invalid ranges, exact and irrational-like targets
        send_target('0);
        send_target(ONE_FIX);
        send_target(ONE_FIX + 1);
        send_target({2'b01, 32'hFFFF_FFFF});
        send_target({TGT_W{1'b1}});
        send_target({1'b1, {(TGT_W-1){1'b0}}});
        send_target(34'd1);
        send_target(ONE_FIX - 1);
        send_target(ONE_FIX >> 1);
        send_target(34'h0_5555_5555);
        send_target(34'h0_AAAA_AAAB);
        send_target(34'h0_9E37_79B9);
        send_target(34'h0_243F_6A88);
        send_target(34'h0_B504_F333);
        send_target(34'h0_0001_0000);
        send_target(34'h0_0010_0101);
        for (i = 0; i < 120; i++)
            send_target(random_target());

        for (ph = 0; ph < 8; ph++)
        begin
            write_den_limit(ph == 7 ? 16'($urandom) : limits[ph]);
            send_target('0);
            send_target(ONE_FIX);
            send_target(34'h0_9E37_79B9);
            for (i = 0; i < 120; i++)
                send_target(random_target());
        end

        wait (fractions_pending == 0);
        repeat (200) @(negedge clk);
        if (fraction_errors == 0 && fractions_pending == 0)
            $display("best_rational_approximation_core: match");
        else
            $display("best_rational_approximation_core: mismatch");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/brat_pkg.sv
rtl/brat_alu.sv
rtl/best_rational_approximation_core.sv
tb/best_rational_approximation_checker.sv
tb/best_rational_approximation_core_tb.sv
